@@ rtl/rgbhsv_pkg.sv @@
// ============================================================================
// rgbhsv_pkg: shared types and constants of the RGB to HSV pixel unit
// Holds the class word that travels from the front to the back, the queue
// sizes and the hue sector offsets.
// ============================================================================
package rgbhsv_pkg;

   // Hue sector chosen by the largest component; gray when max equals min.
   typedef enum logic [1:0] {
      SECTOR_GRAY,
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   // Classified pixel handed from the front to the back.
   typedef struct packed {
      sector_type        sector;
      logic signed [8:0] diff;     // component difference for the sector
      logic [7:0]        delta;    // max - min
      logic [7:0]        maxval;   // largest component
   } class_type;

   // Middle queue between front and back.
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
   typedef logic [Q_PTR_W-1:0] q_ptr_type;
   typedef logic [Q_CNT_W-1:0] q_cnt_type;
   localparam q_cnt_type Q_FULL_CNT = q_cnt_type'(Q_DEPTH);

   // Output queue; deeper than the divider pipeline so that full rate holds.
   localparam int OUT_DEPTH = 16;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
   typedef logic [OUT_PTR_W-1:0] out_ptr_type;
   typedef logic [OUT_CNT_W-1:0] out_cnt_type;
   localparam out_cnt_type OUT_FULL_CNT = out_cnt_type'(OUT_DEPTH);

   // Restoring divider: one quotient bit per pipeline stage.
   localparam int DIV_STEPS = 8;
   localparam int QIDX_W    = $clog2(DIV_STEPS);
   localparam int REM_W     = 17;
   localparam int DEN_W     = 9;
   typedef logic [QIDX_W-1:0] qidx_type;
   typedef logic [REM_W-1:0]  rem_type;
   typedef logic [DEN_W-1:0]  den_type;

   // Hue offsets after the quotient has been biased by +60 degrees.
   localparam logic [8:0] HUE_BASE_RED   = 9'd300;
   localparam logic [8:0] HUE_BASE_GREEN = 9'd60;
   localparam logic [8:0] HUE_BASE_BLUE  = 9'd180;
   localparam logic [8:0] HUE_WRAP       = 9'd360;

endpackage

@@ rtl/rgbhsv_front.sv @@
// ============================================================================
// rgbhsv_front: pixel intake and sector classification
// Finds max, min and delta of the three components, picks the hue sector
// and registers the class word for the middle queue.
// ============================================================================
module rgbhsv_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic [23:0]           req_pixel_rgb,
   output logic                  req_full,
   input  logic                  q_full,
   output logic                  q_push,
   output rgbhsv_pkg::class_type q_data
);

   logic                  vld_ff, vld_in;
   rgbhsv_pkg::class_type cls_ff, cls_in;
   logic                  accept;
   logic [7:0]            red, green, blue, mn;

   assign red   = req_pixel_rgb[23:16];
   assign green = req_pixel_rgb[15:8];
   assign blue  = req_pixel_rgb[7:0];

   // The stage frees up in the same cycle that it moves into the queue.
   assign req_full = vld_ff && q_full;
   assign accept   = req_push && !req_full;
   assign q_push   = vld_ff && !q_full;
   assign q_data   = cls_ff;

   always_comb begin
      cls_in = '0;
      if (red >= green && red >= blue) begin
         cls_in.maxval = red;
         cls_in.sector = rgbhsv_pkg::SECTOR_RED;
         cls_in.diff   = $signed({1'b0, green}) - $signed({1'b0, blue});
      end else if (green >= blue) begin
         cls_in.maxval = green;
         cls_in.sector = rgbhsv_pkg::SECTOR_GREEN;
         cls_in.diff   = $signed({1'b0, blue}) - $signed({1'b0, red});
      end else begin
         cls_in.maxval = blue;
         cls_in.sector = rgbhsv_pkg::SECTOR_BLUE;
         cls_in.diff   = $signed({1'b0, red}) - $signed({1'b0, green});
      end
      mn = (red < green) ? red : green;
      mn = (mn < blue) ? mn : blue;
      cls_in.delta = cls_in.maxval - mn;
      if (cls_in.delta == 8'd0) begin
         cls_in.sector = rgbhsv_pkg::SECTOR_GRAY;
      end
   end

   assign vld_in = accept || (vld_ff && q_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cls_ff <= cls_in;
      end
   end

endmodule

@@ rtl/rgbhsv_queue.sv @@
// ============================================================================
// rgbhsv_queue: short queue of class words between front and back
// A small register queue that lets the front and the back stall on their own.
// ============================================================================
module rgbhsv_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rgbhsv_pkg::class_type push_data,
   output logic                  full,
   input  logic                  pop,
   output rgbhsv_pkg::class_type pop_data,
   output logic                  empty
);

   rgbhsv_pkg::class_type  mem_ff [0:rgbhsv_pkg::Q_DEPTH-1];
   rgbhsv_pkg::q_ptr_type  wr_ptr_ff, wr_ptr_in;
   rgbhsv_pkg::q_ptr_type  rd_ptr_ff, rd_ptr_in;
   rgbhsv_pkg::q_cnt_type  cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign full     = (cnt_ff == rgbhsv_pkg::Q_FULL_CNT);
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + rgbhsv_pkg::q_ptr_type'(1);
         cnt_in    = cnt_in + rgbhsv_pkg::q_cnt_type'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + rgbhsv_pkg::q_ptr_type'(1);
         cnt_in    = cnt_in - rgbhsv_pkg::q_cnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/rgbhsv_back.sv @@
// ============================================================================
// rgbhsv_back: hue and saturation dividers with output queue
// Two restoring dividers run side by side, one quotient bit per stage, and
// finished words land in an output queue whose room is reserved at issue.
// ============================================================================
module rgbhsv_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  rgbhsv_pkg::class_type q_data,
   output logic                  q_pop,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output logic [8:0]            rsp_hue_degrees,
   output logic [7:0]            rsp_saturation,
   output logic [7:0]            rsp_brightness
);

   typedef struct packed {
      rgbhsv_pkg::sector_type sector;
      logic [7:0]             maxval;
      rgbhsv_pkg::rem_type    hue_rem;
      rgbhsv_pkg::rem_type    sat_rem;
      rgbhsv_pkg::den_type    hue_den;
      rgbhsv_pkg::den_type    sat_den;
      logic [7:0]             hue_quo;
      logic [7:0]             sat_quo;
   } div_type;

   typedef struct packed {
      logic [8:0] hue;
      logic [7:0] sat;
      logic [7:0] bright;
   } rsp_type;

   // One restoring step: try the divisor shifted to the current quotient bit.
   function automatic div_type div_step(input div_type s, input rgbhsv_pkg::qidx_type sh);
      div_type             t;
      rgbhsv_pkg::rem_type hd;
      rgbhsv_pkg::rem_type sd;
      t  = s;
      hd = rgbhsv_pkg::rem_type'(s.hue_den) << sh;
      sd = rgbhsv_pkg::rem_type'(s.sat_den) << sh;
      if (s.hue_rem >= hd) begin
         t.hue_rem     = s.hue_rem - hd;
         t.hue_quo[sh] = 1'b1;
      end
      if (s.sat_rem >= sd) begin
         t.sat_rem     = s.sat_rem - sd;
         t.sat_quo[sh] = 1'b1;
      end
      return t;
   endfunction

   div_type                 stg_ff [0:rgbhsv_pkg::DIV_STEPS];
   div_type                 stg_in [0:rgbhsv_pkg::DIV_STEPS];
   logic [rgbhsv_pkg::DIV_STEPS:0] vld_ff, vld_in;
   logic signed [17:0]      hue_num;
   div_type                 head;

   rsp_type                 mem_ff [0:rgbhsv_pkg::OUT_DEPTH-1];
   rsp_type                 done;
   rgbhsv_pkg::out_ptr_type wr_ptr_ff, wr_ptr_in;
   rgbhsv_pkg::out_ptr_type rd_ptr_ff, rd_ptr_in;
   rgbhsv_pkg::out_cnt_type cnt_ff, cnt_in;
   rgbhsv_pkg::out_cnt_type rsv_ff, rsv_in;
   logic                    issue, push_out, pop_out;
   logic [8:0]              hue_sum;
   div_type                 last;

   // A word is only issued when a place in the output queue is held for it.
   assign issue = !q_empty && (rsv_ff < rgbhsv_pkg::OUT_FULL_CNT);
   assign q_pop = issue;

   // Hue numerator is biased by +60 degrees so it is never negative:
   // 120*diff + 121*delta over 2*delta.
   always_comb begin
      head        = '0;
      hue_num     = 18'(q_data.diff) * 18'sd120 + $signed({10'd0, q_data.delta}) * 18'sd121;
      head.sector = q_data.sector;
      head.maxval = q_data.maxval;
      head.hue_rem = hue_num[rgbhsv_pkg::REM_W-1:0];
      head.hue_den = {q_data.delta, 1'b0};
      head.sat_rem = rgbhsv_pkg::rem_type'(q_data.delta) * rgbhsv_pkg::rem_type'(510)
                     + rgbhsv_pkg::rem_type'(q_data.maxval);
      head.sat_den = {q_data.maxval, 1'b0};
   end

   assign stg_in[0] = head;
   assign vld_in[0] = issue;

   for (genvar k = 0; k < rgbhsv_pkg::DIV_STEPS; k++) begin : g_div
      assign stg_in[k+1] = div_step(stg_ff[k],
                                    rgbhsv_pkg::qidx_type'(rgbhsv_pkg::DIV_STEPS - 1 - k));
      assign vld_in[k+1] = vld_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      stg_ff <= stg_in;
   end

   // Undo the bias, add the sector offset and wrap into 0..359.
   assign last = stg_ff[rgbhsv_pkg::DIV_STEPS];

   always_comb begin
      hue_sum = '0;
      unique case (last.sector)
         rgbhsv_pkg::SECTOR_RED: begin
            hue_sum = {1'b0, last.hue_quo} + rgbhsv_pkg::HUE_BASE_RED;
            if (hue_sum >= rgbhsv_pkg::HUE_WRAP) begin
               hue_sum = hue_sum - rgbhsv_pkg::HUE_WRAP;
            end
         end
         rgbhsv_pkg::SECTOR_GREEN: hue_sum = {1'b0, last.hue_quo} + rgbhsv_pkg::HUE_BASE_GREEN;
         rgbhsv_pkg::SECTOR_BLUE:  hue_sum = {1'b0, last.hue_quo} + rgbhsv_pkg::HUE_BASE_BLUE;
         default:                  hue_sum = '0;
      endcase
      done.hue    = hue_sum;
      done.sat    = (last.maxval == 8'd0) ? 8'd0 : last.sat_quo;
      done.bright = last.maxval;
   end

   assign push_out  = vld_ff[rgbhsv_pkg::DIV_STEPS];
   assign rsp_empty = (cnt_ff == '0);
   assign pop_out   = rsp_pop && !rsp_empty;

   assign rsp_hue_degrees = mem_ff[rd_ptr_ff].hue;
   assign rsp_saturation  = mem_ff[rd_ptr_ff].sat;
   assign rsp_brightness  = mem_ff[rd_ptr_ff].bright;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      rsv_in    = rsv_ff;
      if (push_out) begin
         wr_ptr_in = wr_ptr_ff + rgbhsv_pkg::out_ptr_type'(1);
         cnt_in    = cnt_in + rgbhsv_pkg::out_cnt_type'(1);
      end
      if (issue) begin
         rsv_in = rsv_in + rgbhsv_pkg::out_cnt_type'(1);
      end
      if (pop_out) begin
         rd_ptr_in = rd_ptr_ff + rgbhsv_pkg::out_ptr_type'(1);
         cnt_in    = cnt_in - rgbhsv_pkg::out_cnt_type'(1);
         rsv_in    = rsv_in - rgbhsv_pkg::out_cnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
         rsv_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
         rsv_ff    <= rsv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_out) begin
         mem_ff[wr_ptr_ff] <= done;
      end
   end

endmodule

@@ rtl/rgb_to_hsv_pixel_unit.sv @@
// ============================================================================
// rgb_to_hsv_pixel_unit: RGB to HSV stream, one pixel per clock unless stalled
// Converts packed 24-bit RGB words to hue in degrees, saturation and value.
// ============================================================================
// Usage. Both sides look like a queue. A word is written when req_push is
// high and req_full is low; req_pixel_rgb carries red in bits 23..16, green
// in 15..8 and blue in 7..0. A result word is waiting while rsp_empty is low
// and is taken at an edge where rsp_pop is high.
// A result passes the front register, the middle queue and the eight-stage
// divider pipeline (one quotient bit per stage for both hue and saturation)
// before it is written into the output queue and rsp_empty goes low.
// Throughput is one word per clock: the front takes a new pixel in every
// cycle while the dividers work, and results pile up in a 16-word output
// queue. A word enters the dividers only when its place in that queue is
// reserved, so a stalled receiver first fills the output queue, then the
// four-word middle queue and the front register, and only then raises
// req_full. Nothing is lost or dropped under backpressure.
// Synchronous reset empties every queue and the pipeline; nothing needs
// clearing beyond that, and the block takes words on the first cycle after.
// ============================================================================
module rgb_to_hsv_pixel_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [23:0] req_pixel_rgb,
   output logic        req_full,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [8:0]  rsp_hue_degrees,
   output logic [7:0]  rsp_saturation,
   output logic [7:0]  rsp_brightness
);

   // Class words between the front and the middle queue.
   rgbhsv_pkg::class_type front_data;
   logic                  front_push;
   logic                  mid_full;

   // Class words between the middle queue and the dividers.
   rgbhsv_pkg::class_type mid_data;
   logic                  mid_empty;
   logic                  mid_pop;

   // The front finds the largest and smallest components, picks the hue sector and the delta.
   rgbhsv_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_pixel_rgb (req_pixel_rgb),
      .req_full      (req_full),
      .q_full        (mid_full),
      .q_push        (front_push),
      .q_data        (front_data)
   );

   rgbhsv_queue u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_data),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_data),
      .empty     (mid_empty)
   );

   // The back runs both divisions and holds the finished words.
   rgbhsv_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (mid_empty),
      .q_data          (mid_data),
      .q_pop           (mid_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_hue_degrees (rsp_hue_degrees),
      .rsp_saturation  (rsp_saturation),
      .rsp_brightness  (rsp_brightness)
   );

   // Saturation is zero only for gray pixels, and those have hue zero.
   a_gray_hue: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_saturation == 8'd0) |-> (rsp_hue_degrees == 9'd0))
      else $error("nonzero hue on a gray result word");

   // The sector offset and wrap keep hue inside one turn.
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_hue_degrees < 9'd360))
      else $error("hue out of range");

   // A black pixel has no chroma, so its saturation must be forced to zero.
   a_black_sat: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_brightness == 8'd0) |-> (rsp_saturation == 8'd0))
      else $error("nonzero saturation on a black result word");

   // Right after reset, no result word may be waiting in the output queue.
   a_no_phantom: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> rsp_empty)
      else $error("result word present right after reset");

endmodule
